@@ design/per_transmitter_frame_tally_macros.svh @@
// Assertion macros for the per-transmitter frame tally.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef PER_TRANSMITTER_FRAME_TALLY_MACROS_SVH
`define PER_TRANSMITTER_FRAME_TALLY_MACROS_SVH

`ifndef SYNTHESIS
`define PTFT_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptft: same-cycle check failed");
`define PTFT_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptft: next-cycle check failed");
`else
`define PTFT_ASSERT_IMP(name, ante, cons)
`define PTFT_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ design/ptft_pkg.sv @@
// Shared types and constants for the per-transmitter frame tally.
// No dependencies.
`timescale 1ns / 1ps

package ptft_pkg;

   localparam int TABLE_DEPTH = 48;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int CMD_W  = 2;
   localparam int KIND_W = 2;
   localparam int LEN_W  = 12;
   localparam int RSSI_W = 8;
   localparam int CHAN_W = 4;
   localparam int ADDR_W = 48;
   localparam int CTR_W  = 32;
   localparam int SUB_W  = 16;
   localparam int USED_W = 6;

   localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_MGMT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;

   localparam logic [LEN_W-1:0]         MIN_LEN   = 12'd16;
   localparam int                       GROUP_BIT = 40;
   localparam logic signed [RSSI_W-1:0] NEW_RSSI  = -8'sd127;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [LEN_W-1:0]         length;
      logic signed [RSSI_W-1:0] rssi;
      logic [CHAN_W-1:0]        channel;
      logic [ADDR_W-1:0]        addr;
   } frame_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [RSSI_W-1:0] rssi;
      logic [CHAN_W-1:0]        channel;
      logic [CTR_W-1:0]         frames;
      logic [CTR_W-1:0]         bytes;
      logic [SUB_W-1:0]         mgmt;
      logic [SUB_W-1:0]         data;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      entry_type          entry;
      logic [CTR_W-1:0]   total;
      logic [USED_W-1:0]  used;
      logic               valid;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_EMPTY
   } state_type;

endpackage

@@ design/ptft_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds when no read is issued. No dependencies.
`timescale 1ns / 1ps

module ptft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ptft_upd.sv @@
// Entry update: folds one counted frame into a table entry.
// Depends on ptft_pkg.
`timescale 1ns / 1ps

module ptft_upd import ptft_pkg::*; (
   input  entry_type old_entry,
   input  frame_type frame,
   output entry_type new_entry
);

   always_comb begin
      new_entry         = old_entry;
      if ($signed(frame.rssi) > $signed(old_entry.rssi)) begin
         new_entry.rssi = frame.rssi;
      end
      new_entry.channel = frame.channel;
      new_entry.frames  = old_entry.frames + CTR_W'(1);
      new_entry.bytes   = old_entry.bytes + CTR_W'(frame.length);
      if (frame.kind == KIND_MGMT) begin
         new_entry.mgmt = old_entry.mgmt + SUB_W'(1);
      end else begin
         new_entry.data = old_entry.data + SUB_W'(1);
      end
   end

endmodule

@@ design/per_transmitter_frame_tally.sv @@
// Frame request: scans the entries in order through the single read port until a
// match or the end of the entry count; a hit, or a miss with room, is written back.
// Dump: reads each entry and returns one result per entry, held by output stalls; an
// empty dump gives one result. Clear and ignored requests need no table access.
// One request is worked at a time. Reset zeroes the entry count and byte total;
// the memory is not cleared, and entries past the count are never read.
`timescale 1ns / 1ps
`include "per_transmitter_frame_tally_macros.svh"

module per_transmitter_frame_tally import ptft_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [KIND_W-1:0]         req_frame_kind,
   input  logic [LEN_W-1:0]          req_frame_length,
   input  logic signed [RSSI_W-1:0]  req_frame_rssi,
   input  logic [CHAN_W-1:0]         req_frame_channel,
   input  logic [ADDR_W-1:0]         req_transmitter_address,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ADDR_W-1:0]         rsp_entry_address,
   output logic signed [RSSI_W-1:0]  rsp_best_rssi,
   output logic [CHAN_W-1:0]         rsp_last_channel,
   output logic [CTR_W-1:0]          rsp_frame_count,
   output logic [CTR_W-1:0]          rsp_byte_count,
   output logic [SUB_W-1:0]          rsp_management_count,
   output logic [SUB_W-1:0]          rsp_data_count,
   output logic [CTR_W-1:0]          rsp_total_bytes,
   output logic [USED_W-1:0]         rsp_entries_used,
   output logic                      rsp_entry_valid,
   output logic                      rsp_last_entry
);

   state_type        state_ff, state_in;
   frame_type        frame_ff, frame_in;
   entry_type        entry_ff, entry_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             append_ff, append_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CTR_W-1:0] total_ff, total_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   frame_type        req_frame;
   entry_type        rd_data, wr_data, fresh_entry;
   logic             req_take, counts, issue, hit, miss, has_room, out_free, dump_last;
   logic             rd_en, wr_en, rsp_load;
   logic [IDX_W-1:0] rd_addr;

   assign req_frame = '{kind: req_frame_kind, length: req_frame_length, rssi: req_frame_rssi,
                        channel: req_frame_channel, addr: req_transmitter_address};
   assign req_take  = req_valid && !req_stall;
   assign counts    = ((req_frame_kind == KIND_MGMT) || (req_frame_kind == KIND_DATA))
                      && (req_frame_length >= MIN_LEN) && !req_transmitter_address[GROUP_BIT];

   assign issue     = scan_ff < used_ff;
   assign hit       = pend_ff && (rd_data.addr == frame_ff.addr);
   assign miss      = !pend_ff && !issue;
   assign has_room  = used_ff < CNT_W'(TABLE_DEPTH);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dump_last = (scan_ff + CNT_W'(1)) == used_ff;
   assign rd_addr   = scan_ff[IDX_W-1:0];

   assign fresh_entry = '{addr: frame_ff.addr, rssi: NEW_RSSI, channel: '0, frames: '0,
                          bytes: '0, mgmt: '0, data: '0};

   ptft_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptft_upd u_upd (
      .old_entry (entry_ff),
      .frame     (frame_ff),
      .new_entry (wr_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_command)
                  CMD_FRAME: state_in = counts ? ST_SEARCH : ST_IDLE;
                  CMD_DUMP:  state_in = (used_ff == '0) ? ST_EMPTY : ST_DUMP_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit || (miss && has_room)) begin
               state_in = ST_WRITE;
            end else if (miss) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE:    state_in = ST_IDLE;
         ST_DUMP_RD:  state_in = ST_DUMP_OUT;
         ST_DUMP_OUT: begin
            if (out_free) begin
               state_in = dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_stall = 1'b0;
         ST_SEARCH:   rd_en     = issue;
         ST_WRITE:    wr_en     = 1'b1;
         ST_DUMP_RD:  rd_en     = 1'b1;
         ST_DUMP_OUT: rsp_load  = out_free;
         ST_EMPTY:    rsp_load  = out_free;
         default:     req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      frame_in    = frame_ff;
      entry_in    = entry_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = scan_ff;
      slot_in     = slot_ff;
      append_in   = append_ff;
      used_in     = used_ff;
      total_in    = total_ff;
      rsp_in      = rsp_ff;

      if (state_ff == ST_IDLE && req_take) begin
         frame_in = req_frame;
         scan_in  = '0;
         if (req_command == CMD_CLEAR) begin
            used_in  = '0;
            total_in = '0;
         end
      end

      if (state_ff == ST_SEARCH) begin
         pend_in = issue;
         if (issue) begin
            scan_in = scan_ff + CNT_W'(1);
         end
         if (hit) begin
            entry_in  = rd_data;
            slot_in   = pend_idx_ff[IDX_W-1:0];
            append_in = 1'b0;
         end else if (miss) begin
            entry_in  = fresh_entry;
            slot_in   = used_ff[IDX_W-1:0];
            append_in = 1'b1;
         end
      end

      if (wr_en) begin
         used_in  = used_ff + CNT_W'(append_ff);
         total_in = total_ff + CTR_W'(frame_ff.length);
      end

      if (state_ff == ST_DUMP_OUT && rsp_load) begin
         rsp_in  = '{entry: rd_data, total: total_ff, used: USED_W'(used_ff),
                     valid: 1'b1, last: dump_last};
         scan_in = scan_ff + CNT_W'(1);
      end

      if (state_ff == ST_EMPTY && rsp_load) begin
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      entry_ff    <= entry_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      append_ff   <= append_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entry_address    = rsp_ff.entry.addr;
   assign rsp_best_rssi        = rsp_ff.entry.rssi;
   assign rsp_last_channel     = rsp_ff.entry.channel;
   assign rsp_frame_count      = rsp_ff.entry.frames;
   assign rsp_byte_count       = rsp_ff.entry.bytes;
   assign rsp_management_count = rsp_ff.entry.mgmt;
   assign rsp_data_count       = rsp_ff.entry.data;
   assign rsp_total_bytes      = rsp_ff.total;
   assign rsp_entries_used     = rsp_ff.used;
   assign rsp_entry_valid      = rsp_ff.valid;
   assign rsp_last_entry       = rsp_ff.last;

   `PTFT_ASSERT_IMP(a_used_bound, 1'b1, used_ff <= CNT_W'(TABLE_DEPTH))
   `PTFT_ASSERT_IMP(a_write_slot, state_ff == ST_WRITE, append_ff ? (CNT_W'(slot_ff) == used_ff) : (CNT_W'(slot_ff) < used_ff))
   `PTFT_ASSERT_NXT(a_clear_empties, req_take && (req_command == CMD_CLEAR), (used_ff == '0) && (total_ff == '0))
   `PTFT_ASSERT_NXT(a_last_to_idle, rsp_load && rsp_in.last, state_ff == ST_IDLE)

endmodule

@@ test/per_transmitter_frame_tally_tb.sv @@
// Testbench for the per-transmitter frame tally: directed and random requests,
// checked against a predictor of the entry table. Depends on ptft_pkg and the block.
`timescale 1ns / 1ps

module per_transmitter_frame_tally_tb import ptft_pkg::*; ();

   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_command;
   logic [KIND_W-1:0]         req_frame_kind;
   logic [LEN_W-1:0]          req_frame_length;
   logic signed [RSSI_W-1:0]  req_frame_rssi;
   logic [CHAN_W-1:0]         req_frame_channel;
   logic [ADDR_W-1:0]         req_transmitter_address;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [ADDR_W-1:0]         rsp_entry_address;
   logic signed [RSSI_W-1:0]  rsp_best_rssi;
   logic [CHAN_W-1:0]         rsp_last_channel;
   logic [CTR_W-1:0]          rsp_frame_count;
   logic [CTR_W-1:0]          rsp_byte_count;
   logic [SUB_W-1:0]          rsp_management_count;
   logic [SUB_W-1:0]          rsp_data_count;
   logic [CTR_W-1:0]          rsp_total_bytes;
   logic [USED_W-1:0]         rsp_entries_used;
   logic                      rsp_entry_valid;
   logic                      rsp_last_entry;

   // Predicted table contents
   entry_type        tally_table [TABLE_DEPTH];
   int unsigned      tally_used = 0;
   logic [CTR_W-1:0] tally_bytes = '0;
   rsp_type          expected_dump_lines [$];

   int error_count = 0;
   int burst_left  = 0;

   per_transmitter_frame_tally i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_frame_kind          (req_frame_kind),
      .req_frame_length        (req_frame_length),
      .req_frame_rssi          (req_frame_rssi),
      .req_frame_channel       (req_frame_channel),
      .req_transmitter_address (req_transmitter_address),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_entry_address       (rsp_entry_address),
      .rsp_best_rssi           (rsp_best_rssi),
      .rsp_last_channel        (rsp_last_channel),
      .rsp_frame_count         (rsp_frame_count),
      .rsp_byte_count          (rsp_byte_count),
      .rsp_management_count    (rsp_management_count),
      .rsp_data_count          (rsp_data_count),
      .rsp_total_bytes         (rsp_total_bytes),
      .rsp_entries_used        (rsp_entries_used),
      .rsp_entry_valid         (rsp_entry_valid),
      .rsp_last_entry          (rsp_last_entry)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic frame_type frame_of(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
                                          logic signed [RSSI_W-1:0] rssi,
                                          logic [CHAN_W-1:0] chan, logic [ADDR_W-1:0] addr);
      frame_type f;
      f.kind    = kind;
      f.length  = len;
      f.rssi    = rssi;
      f.channel = chan;
      f.addr    = addr;
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      f.kind    = KIND_W'($urandom);
      f.length  = LEN_W'($urandom);
      f.rssi    = RSSI_W'($urandom);
      f.channel = CHAN_W'($urandom);
      f.addr    = ADDR_W'({$urandom, $urandom});
      return f;
   endfunction

   // Apply one accepted request to the predicted table; queue any dump lines.
   task automatic tally_predict(logic [CMD_W-1:0] cmd, frame_type f);
      int          slot;
      int unsigned i;
      rsp_type     line;
      slot = -1;
      if (cmd == CMD_CLEAR) begin
         tally_used  = 0;
         tally_bytes = '0;
      end else if (cmd == CMD_DUMP) begin
         if (tally_used == 0) begin
            line      = '0;
            line.last = 1'b1;
            expected_dump_lines.push_back(line);
         end else begin
            for (i = 0; i < tally_used; i++) begin
               line.entry = tally_table[i];
               line.total = tally_bytes;
               line.used  = tally_used[USED_W-1:0];
               line.valid = 1'b1;
               line.last  = (i == tally_used - 1);
               expected_dump_lines.push_back(line);
            end
         end
      end else if (cmd == CMD_FRAME) begin
         if (f.kind != KIND_MGMT && f.kind != KIND_DATA) return;
         if (f.length < MIN_LEN) return;
         if (f.addr[GROUP_BIT]) return;
         for (i = 0; i < tally_used; i++) begin
            if (tally_table[i].addr == f.addr) begin
               slot = i;
               break;
            end
         end
         if (slot < 0) begin
            if (tally_used >= TABLE_DEPTH) return;
            slot = tally_used;
            tally_used++;
            tally_table[slot]      = '0;
            tally_table[slot].addr = f.addr;
            tally_table[slot].rssi = NEW_RSSI;
         end
         if ($signed(f.rssi) > $signed(tally_table[slot].rssi)) tally_table[slot].rssi = f.rssi;
         tally_table[slot].channel = f.channel;
         tally_table[slot].frames  = tally_table[slot].frames + CTR_W'(1);
         tally_table[slot].bytes   = tally_table[slot].bytes + CTR_W'(f.length);
         if (f.kind == KIND_MGMT) tally_table[slot].mgmt = tally_table[slot].mgmt + SUB_W'(1);
         else tally_table[slot].data = tally_table[slot].data + SUB_W'(1);
         tally_bytes = tally_bytes + CTR_W'(f.length);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [CMD_W-1:0] cmd, frame_type f);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid               = 1'b1;
      req_command             = cmd;
      req_frame_kind          = f.kind;
      req_frame_length        = f.length;
      req_frame_rssi          = f.rssi;
      req_frame_channel       = f.channel;
      req_transmitter_address = f.addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tally_predict(cmd, f);
      @(negedge clock);
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dump_lines.size() == 0) begin
            $error("unexpected dump line for address %h", rsp_entry_address);
            error_count++;
         end else begin
            want = expected_dump_lines.pop_front();
            check_field("entry_address", longint'(want.entry.addr),
                        longint'(rsp_entry_address));
            check_field("best_rssi", longint'($signed(want.entry.rssi)),
                        longint'($signed(rsp_best_rssi)));
            check_field("last_channel", longint'(want.entry.channel),
                        longint'(rsp_last_channel));
            check_field("frame_count", longint'(want.entry.frames), longint'(rsp_frame_count));
            check_field("byte_count", longint'(want.entry.bytes), longint'(rsp_byte_count));
            check_field("management_count", longint'(want.entry.mgmt),
                        longint'(rsp_management_count));
            check_field("data_count", longint'(want.entry.data), longint'(rsp_data_count));
            check_field("total_bytes", longint'(want.total), longint'(rsp_total_bytes));
            check_field("entries_used", longint'(want.used), longint'(rsp_entries_used));
            check_field("entry_valid", longint'(want.valid), longint'(rsp_entry_valid));
            check_field("last_entry", longint'(want.last), longint'(rsp_last_entry));
         end
      end
   end

   // Receiver stall pattern, switching among four random modes
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = 1'($urandom_range(0, 1));
               2: rsp_stall = ($urandom_range(0, 9) < 8);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   task automatic test_empty_dump();
      send_request(CMD_DUMP, random_frame());
      send_request(CMD_UNUSED, random_frame());
      send_request(CMD_DUMP, random_frame());
   endtask

   task automatic test_frame_filters();
      logic [ADDR_W-1:0] addr;
      addr = 48'h0200_0000_0001;
      send_request(CMD_FRAME, frame_of(KIND_OTHER, 12'd100, -8'sd40, 4'd3, addr));
      send_request(CMD_FRAME, frame_of(KIND_SPARE, 12'd100, -8'sd40, 4'd3, addr));
      send_request(CMD_FRAME, frame_of(KIND_MGMT, 12'd15, -8'sd40, 4'd3, addr));
      send_request(CMD_FRAME, frame_of(KIND_DATA, 12'd0, -8'sd40, 4'd3, addr));
      addr[GROUP_BIT] = 1'b1;
      send_request(CMD_FRAME, frame_of(KIND_DATA, 12'd200, -8'sd40, 4'd3, addr));
      send_request(CMD_DUMP, random_frame());
   endtask

   task automatic test_new_entry_rules();
      // -128 dBm on a fresh entry must leave it at -127
      send_request(CMD_FRAME, frame_of(KIND_MGMT, MIN_LEN, 8'sh80, 4'd0, 48'h0));
      send_request(CMD_FRAME, frame_of(KIND_DATA, 12'd4095, 8'sd127, 4'd15,
                                       48'hFEFF_FFFF_FFFF));
      send_request(CMD_FRAME, frame_of(KIND_MGMT, 12'd100, -8'sd50, 4'd7, 48'h0));
      send_request(CMD_FRAME, frame_of(KIND_DATA, 12'd4095, -8'sd90, 4'd9, 48'h0));
      send_request(CMD_DUMP, random_frame());
   endtask

   task automatic test_clear();
      send_request(CMD_CLEAR, random_frame());
      send_request(CMD_DUMP, random_frame());
      send_request(CMD_FRAME, frame_of(KIND_DATA, 12'd64, -8'sd20, 4'd11, 48'h0000_1234_5678));
      send_request(CMD_DUMP, random_frame());
      send_request(CMD_CLEAR, random_frame());
   endtask

   task automatic test_table_full();
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] first_addr;
      frame_type         f;
      int                i;
      first_addr = '0;
      for (i = 0; i <= TABLE_DEPTH; i++) begin
         addr            = ADDR_W'({$urandom, $urandom});
         addr[15:0]      = i[15:0];
         addr[GROUP_BIT] = 1'b0;
         if (i == 0) first_addr = addr;
         f      = random_frame();
         f.kind = KIND_W'($urandom_range(0, 1));
         f.length = LEN_W'($urandom_range(MIN_LEN, 4095));
         f.addr = addr;
         send_request(CMD_FRAME, f);
      end
      // table full: existing address still counts
      send_request(CMD_FRAME, frame_of(KIND_MGMT, 12'd500, 8'sd10, 4'd5, first_addr));
      send_request(CMD_DUMP, random_frame());
      send_request(CMD_CLEAR, random_frame());
   endtask

   task automatic test_random_traffic();
      logic [ADDR_W-1:0] pool [64];
      frame_type         f;
      int                pool_size;
      int                pick;
      int                i;
      pool_size = 8;
      for (i = 0; i < 64; i++) begin
         pool[i]            = ADDR_W'({$urandom, $urandom});
         pool[i][7:0]       = i[7:0];
         pool[i][GROUP_BIT] = 1'b0;
      end
      for (i = 0; i < 340; i++) begin
         if (i % 100 == 0) pool_size = $urandom_range(4, 64);
         pick = $urandom_range(0, 99);
         f    = random_frame();
         if (pick < 80) begin
            f.kind   = KIND_W'($urandom_range(0, 1));
            f.length = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(MIN_LEN, 80))
                                                   : LEN_W'($urandom_range(MIN_LEN, 4095));
            f.addr   = pool[$urandom_range(0, pool_size - 1)];
            send_request(CMD_FRAME, f);
         end else if (pick < 86) begin
            send_request(CMD_DUMP, f);
         end else if (pick < 87) begin
            send_request(CMD_CLEAR, f);
         end else if (pick < 98) begin
            send_request(CMD_FRAME, f);
         end else begin
            send_request(CMD_UNUSED, f);
         end
      end
   endtask

   initial begin
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_command             = CMD_FRAME;
      req_frame_kind          = KIND_MGMT;
      req_frame_length        = '0;
      req_frame_rssi          = '0;
      req_frame_channel       = '0;
      req_transmitter_address = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_dump();
      test_frame_filters();
      test_new_entry_rules();
      test_clear();
      test_table_full();
      test_random_traffic();

      req_valid = 1'b0;
      while (expected_dump_lines.size() != 0) @(negedge clock);
      repeat (2 * TABLE_DEPTH + 16) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
